// ----- src/pov_pkg.sv -----
// Shared types, constants and tables of the polar orbit velocity transform.
package pov_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int FRAC_BITS_DEF    = 12;
  localparam int CNT_W            = 6;
  localparam int IDX_W            = 5;
  localparam int DIV_BITS         = 48;
  localparam int RADIUS_W         = 24;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 20;
  localparam int IN_DATA_W        = 96;
  localparam int OUT_DATA_W       = 40;
  localparam logic [15:0] KGAIN   = 16'd39797;
  localparam logic [29:0] INV2PI  = 30'd683565276;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIAL_THR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_PER   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BLUE_SIDE  = 3'd4;

  localparam logic ACT_CAPTURE = 1'b0;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_VSTEP, OP_MULX, OP_CAPT, OP_RMUL, OP_RUPD, OP_TMUL,
    OP_QLO, OP_QHI, OP_QSUM, OP_QADD, OP_DSTEP, OP_THETA, OP_RLOAD, OP_RSTEP,
    OP_MULY, OP_OUTX, OP_OUTY
  } op_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_VEC, ST_VMUL, ST_CAPT, ST_RMUL, ST_RUPD, ST_TMUL, ST_QLO,
    ST_QHI, ST_QSUM, ST_QADD, ST_DIV, ST_THETA, ST_RLOAD, ST_ROT, ST_MULX,
    ST_OUTX, ST_MULY, ST_OUTY
  } state_e;

  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic act;
    logic rzero;
  } sts_t;

  // atan(2^-i) as a binary angle, full turn 2^32
  function automatic logic [31:0] atan_f(input logic [IDX_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2F9;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

// ----- src/pov_ctrl.sv -----
// Sequencer of the orbit transform: walks the datapath through one item.
module pov_ctrl #(
  parameter int CORDIC_STEPS = pov_pkg::CORDIC_STEPS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  pov_pkg::sts_t sts_i,
  output pov_pkg::cmd_t cmd_o
);

  pov_pkg::state_e state_q, state_d;
  logic [pov_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pov_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o.op    = pov_pkg::OP_NONE;
    cmd_o.idx   = cnt_q[pov_pkg::IDX_W-1:0];
    case (state_q)
      pov_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cnt_d      = '0;
        if (in_valid_i) begin
          cmd_o.op = pov_pkg::OP_LOAD;
          state_d  = pov_pkg::ST_VEC;
        end
      end
      pov_pkg::ST_VEC: begin
        cmd_o.op = pov_pkg::OP_VSTEP;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == pov_pkg::CNT_W'(CORDIC_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = (sts_i.act == pov_pkg::ACT_CAPTURE) ? pov_pkg::ST_VMUL
                                                         : pov_pkg::ST_RMUL;
        end
      end
      pov_pkg::ST_VMUL: begin
        cmd_o.op = pov_pkg::OP_MULX;
        state_d  = pov_pkg::ST_CAPT;
      end
      pov_pkg::ST_CAPT: begin
        cmd_o.op = pov_pkg::OP_CAPT;
        state_d  = pov_pkg::ST_IDLE;
      end
      pov_pkg::ST_RMUL: begin
        cmd_o.op = pov_pkg::OP_RMUL;
        state_d  = pov_pkg::ST_RUPD;
      end
      pov_pkg::ST_RUPD: begin
        cmd_o.op = pov_pkg::OP_RUPD;
        state_d  = pov_pkg::ST_TMUL;
      end
      pov_pkg::ST_TMUL: begin
        cmd_o.op = pov_pkg::OP_TMUL;
        // zero radius: no bearing advance, skip the divide
        state_d  = sts_i.rzero ? pov_pkg::ST_THETA : pov_pkg::ST_QLO;
      end
      pov_pkg::ST_QLO: begin
        cmd_o.op = pov_pkg::OP_QLO;
        state_d  = pov_pkg::ST_QHI;
      end
      pov_pkg::ST_QHI: begin
        cmd_o.op = pov_pkg::OP_QHI;
        state_d  = pov_pkg::ST_QSUM;
      end
      pov_pkg::ST_QSUM: begin
        cmd_o.op = pov_pkg::OP_QSUM;
        state_d  = pov_pkg::ST_QADD;
      end
      pov_pkg::ST_QADD: begin
        cmd_o.op = pov_pkg::OP_QADD;
        cnt_d    = '0;
        state_d  = pov_pkg::ST_DIV;
      end
      pov_pkg::ST_DIV: begin
        cmd_o.op = pov_pkg::OP_DSTEP;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == pov_pkg::CNT_W'(pov_pkg::DIV_BITS - 1)) begin
          cnt_d   = '0;
          state_d = pov_pkg::ST_THETA;
        end
      end
      pov_pkg::ST_THETA: begin
        cmd_o.op = pov_pkg::OP_THETA;
        state_d  = pov_pkg::ST_RLOAD;
      end
      pov_pkg::ST_RLOAD: begin
        cmd_o.op = pov_pkg::OP_RLOAD;
        cnt_d    = '0;
        state_d  = pov_pkg::ST_ROT;
      end
      pov_pkg::ST_ROT: begin
        cmd_o.op = pov_pkg::OP_RSTEP;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == pov_pkg::CNT_W'(CORDIC_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = pov_pkg::ST_MULX;
        end
      end
      pov_pkg::ST_MULX: begin
        cmd_o.op = pov_pkg::OP_MULX;
        state_d  = pov_pkg::ST_OUTX;
      end
      pov_pkg::ST_OUTX: begin
        cmd_o.op = pov_pkg::OP_OUTX;
        state_d  = pov_pkg::ST_MULY;
      end
      pov_pkg::ST_MULY: begin
        cmd_o.op = pov_pkg::OP_MULY;
        state_d  = pov_pkg::ST_OUTY;
      end
      pov_pkg::ST_OUTY: begin
        if (out_free) begin
          cmd_o.op    = pov_pkg::OP_OUTY;
          out_valid_d = 1'b1;
          state_d     = pov_pkg::ST_IDLE;
        end
      end
      default: state_d = pov_pkg::ST_IDLE;
    endcase
  end

endmodule

// ----- src/pov_dp.sv -----
// Datapath: config registers, shared CORDIC, shared multiplier, radix-2 divider.
module pov_dp #(
  parameter int FRAC_BITS = pov_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [pov_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [pov_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [pov_pkg::IN_DATA_W-1:0]      in_data_i,
  input  logic                               in_user_i,
  input  pov_pkg::cmd_t                      cmd_i,
  output pov_pkg::sts_t                      sts_o,
  output logic [pov_pkg::OUT_DATA_W-1:0]     out_data_o,
  output logic                               out_user_o
);

  localparam int CW = FRAC_BITS + 24;
  localparam int PW = CW + 31;
  localparam int SH = 16 + FRAC_BITS;

  // configuration
  logic signed [19:0] cx_q, cy_q;
  logic [15:0] thr_q, loop_q;
  logic blue_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q   <= '0;
      cy_q   <= '0;
      thr_q  <= 16'd4608;
      loop_q <= 16'd1311;
      blue_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pov_pkg::CFG_CENTER_X:   cx_q   <= cfg_data_i;
        pov_pkg::CFG_CENTER_Y:   cy_q   <= cfg_data_i;
        pov_pkg::CFG_RADIAL_THR: thr_q  <= cfg_data_i[15:0];
        pov_pkg::CFG_LOOP_PER:   loop_q <= cfg_data_i[15:0];
        pov_pkg::CFG_BLUE_SIDE:  blue_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // working registers
  logic [pov_pkg::RADIUS_W-1:0] radius_q;
  logic signed [CW-1:0] x_q, y_q;
  logic signed [33:0]   z_q;
  logic signed [PW-1:0] prod_q;
  logic [31:0] p_q, theta_q;
  logic [46:0] qlo_q;
  logic [pov_pkg::DIV_BITS-1:0] num_q;
  logic [23:0] rem_q;
  logic act_q, vzero_q, zflag_q;
  logic signed [16:0] rad_q, tang_q;
  logic [15:0] head_q;
  logic signed [17:0] vx_q, ox_q, oy_q;
  logic oz_q;

  // input decode
  logic signed [19:0] px, py;
  logic signed [16:0] rad_in;
  logic signed [20:0] dx, dy;
  logic signed [CW-1:0] gx, gy;
  logic [16:0] rad_in_abs;

  assign px         = in_data_i[19:0];
  assign py         = in_data_i[39:20];
  assign rad_in     = in_data_i[56:40];
  assign dx         = 21'(px) - 21'(cx_q);
  assign dy         = 21'(py) - 21'(cy_q);
  assign gx         = CW'(dx) <<< FRAC_BITS;
  assign gy         = CW'(dy) <<< FRAC_BITS;
  assign rad_in_abs = rad_in[16] ? 17'(-rad_in) : rad_in;

  // CORDIC step
  logic signed [CW-1:0] xs, ys;
  logic [31:0] atan;
  assign xs   = x_q >>> cmd_i.idx;
  assign ys   = y_q >>> cmd_i.idx;
  assign atan = pov_pkg::atan_f(cmd_i.idx);

  // shared multiplier
  logic signed [CW-1:0] mul_a;
  logic signed [30:0]   mul_b;
  logic signed [PW-1:0] prod_d;
  logic [16:0] rad_abs, tang_abs;

  assign rad_abs  = rad_q[16] ? 17'(-rad_q) : rad_q;
  assign tang_abs = tang_q[16] ? 17'(-tang_q) : tang_q;

  always_comb begin
    mul_a = x_q;
    mul_b = 31'(pov_pkg::KGAIN);
    case (cmd_i.op)
      pov_pkg::OP_MULY: mul_a = y_q;
      pov_pkg::OP_RMUL: begin
        mul_a = CW'(rad_abs);
        mul_b = 31'(loop_q);
      end
      pov_pkg::OP_TMUL: begin
        mul_a = CW'(tang_abs);
        mul_b = 31'(loop_q);
      end
      pov_pkg::OP_QLO: begin
        mul_a = CW'(prod_q[15:0]);
        mul_b = 31'(pov_pkg::INV2PI);
      end
      pov_pkg::OP_QHI: begin
        mul_a = CW'(p_q[31:16]);
        mul_b = 31'(pov_pkg::INV2PI);
      end
      default: ;
    endcase
  end
  assign prod_d = mul_a * mul_b;

  // gain-corrected value rounded back to unguarded units
  logic signed [PW-1:0] rnd_v;
  logic signed [17:0] sat_v;
  logic [pov_pkg::RADIUS_W-1:0] mag_v;
  assign rnd_v = (prod_q + (PW'(1) <<< (SH - 1))) >>> SH;

  always_comb begin
    if (rnd_v > PW'(131071))       sat_v = 18'sd131071;
    else if (rnd_v < PW'(-131072)) sat_v = -18'sd131072;
    else                           sat_v = rnd_v[17:0];
    if (rnd_v < PW'(0))                 mag_v = '0;
    else if (rnd_v > PW'(16777215))     mag_v = '1;
    else                                mag_v = rnd_v[23:0];
  end

  // radius update
  logic [16:0] mr;
  logic signed [25:0] r_sum;
  logic [23:0] r_sat;
  assign mr    = 17'((33'(prod_q[31:0]) + 33'd32768) >> 16);
  assign r_sum = rad_q[16] ? 26'(radius_q) - 26'(mr) : 26'(radius_q) + 26'(mr);
  assign r_sat = r_sum[25] ? 24'd0 : (r_sum > 26'sd16777215 ? 24'hFFFFFF : r_sum[23:0]);

  // divide step
  logic [24:0] rem_sh;
  logic [25:0] diff;
  assign rem_sh = {rem_q, num_q[pov_pkg::DIV_BITS-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, radius_q};

  // bearing advance and rotation angle
  logic [31:0] delta, bearing, t_fix;
  logic neg;
  assign delta   = zflag_q ? 32'd0 : (tang_q[16] ? 32'd0 - num_q[31:0] : num_q[31:0]);
  assign bearing = vzero_q ? 32'd0 : z_q[31:0];
  assign neg     = theta_q[31] ^ theta_q[30];
  assign t_fix   = {theta_q[31] ^ neg, theta_q[30:0]};

  logic signed [CW-1:0] rx, ry;
  assign rx = CW'(rad_q) <<< FRAC_BITS;
  assign ry = zflag_q ? '0 : (CW'(tang_q) <<< FRAC_BITS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= '0;
    end else if (cmd_i.op == pov_pkg::OP_CAPT) begin
      radius_q <= mag_v;
    end else if (cmd_i.op == pov_pkg::OP_RUPD) begin
      radius_q <= r_sat;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      pov_pkg::OP_LOAD: begin
        act_q   <= in_user_i;
        vzero_q <= (dx == '0) && (dy == '0);
        rad_q   <= (rad_in_abs <= {1'b0, thr_q}) ? '0 : rad_in;
        tang_q  <= in_data_i[73:57];
        head_q  <= in_data_i[89:74];
        if (dx < 0) begin
          x_q <= -gx;
          y_q <= -gy;
          z_q <= 34'sh080000000;
        end else begin
          x_q <= gx;
          y_q <= gy;
          z_q <= '0;
        end
      end
      pov_pkg::OP_VSTEP: begin
        if (!y_q[CW-1]) begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= {2'b00, z_q[31:0] + atan};
        end else begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= {2'b00, z_q[31:0] - atan};
        end
      end
      pov_pkg::OP_RSTEP: begin
        if (!z_q[33]) begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - 34'(atan);
        end else begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + 34'(atan);
        end
      end
      pov_pkg::OP_MULX, pov_pkg::OP_MULY, pov_pkg::OP_RMUL, pov_pkg::OP_TMUL: begin
        prod_q <= prod_d;
      end
      pov_pkg::OP_RUPD: zflag_q <= (r_sat == '0);
      pov_pkg::OP_QLO: begin
        p_q    <= prod_q[31:0];
        prod_q <= prod_d;
      end
      pov_pkg::OP_QHI: begin
        qlo_q  <= prod_q[46:0];
        prod_q <= prod_d;
      end
      pov_pkg::OP_QSUM: begin
        num_q <= 48'(prod_q[46:0]) + 48'((48'(qlo_q) + 48'd32768) >> 16);
      end
      pov_pkg::OP_QADD: begin
        num_q <= num_q + 48'(radius_q[23:1]);
        rem_q <= '0;
      end
      pov_pkg::OP_DSTEP: begin
        if (!diff[25]) begin
          rem_q <= diff[23:0];
          num_q <= {num_q[pov_pkg::DIV_BITS-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh[23:0];
          num_q <= {num_q[pov_pkg::DIV_BITS-2:0], 1'b0};
        end
      end
      pov_pkg::OP_THETA: begin
        theta_q <= bearing + delta - {head_q, 16'd0} + {blue_q, 31'd0};
      end
      pov_pkg::OP_RLOAD: begin
        x_q <= neg ? -rx : rx;
        y_q <= neg ? -ry : ry;
        z_q <= 34'($signed(t_fix));
      end
      pov_pkg::OP_OUTX: vx_q <= sat_v;
      pov_pkg::OP_OUTY: begin
        ox_q <= vx_q;
        oy_q <= sat_v;
        oz_q <= zflag_q;
      end
      default: ;
    endcase
  end

  assign sts_o.act   = act_q;
  assign sts_o.rzero = zflag_q;
  assign out_data_o  = {4'd0, oy_q, ox_q};
  assign out_user_o  = oz_q;

endmodule

// ----- src/polar_orbit_velocity_transform_core.sv -----
// Top level of the polar orbit velocity transform.
//   channel   dir  content
//   s_axis    in   tdata pos_x/pos_y/radial_cmd/tangential_cmd/heading, tuser action
//   m_axis    out  tdata robot_vx/robot_vy, tuser radius_zero
//   cfg       in   write enable, register index, data
// One item at a time. A capture runs one vectoring CORDIC pass and a gain multiply;
// a drive step runs the two CORDIC passes and the 48-step radix-2 divider, and skips
// the divider when the radius comes out zero.
// A finished result waits in the output register while the next item is taken;
// the block stalls only at its last step if that register is still full.
// Reset clears config to defaults and the target radius to zero.
module polar_orbit_velocity_transform_core #(
  parameter int CORDIC_STEPS = pov_pkg::CORDIC_STEPS_DEF,
  parameter int FRAC_BITS    = pov_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pov_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pov_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // pos_x, pos_y, radial_cmd, tangential_cmd, heading, zero fill
  input  logic [pov_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // action
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // robot_vx, robot_vy, zero fill
  output logic [pov_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // radius_zero
  output logic                           m_axis_tuser
);

  pov_pkg::cmd_t cmd;
  pov_pkg::sts_t sts;

  pov_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pov_dp #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (s_axis_tdata),
    .in_user_i  (s_axis_tuser),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (m_axis_tdata),
    .out_user_o (m_axis_tuser)
  );

endmodule

// ----- tb/pov_checker.sv -----
// Orbit transform checker: tracks config, predicts each drive result, compares outputs.
module pov_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pov_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pov_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [pov_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                           s_axis_tuser,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [pov_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                           m_axis_tuser,
  output int                             err_cnt_o,
  output int                             pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import pov_pkg::*;

  localparam int STEPS = CORDIC_STEPS_DEF;
  localparam int GUARD = FRAC_BITS_DEF;
  localparam longint RMAX = 64'd16777215;
  localparam longint VMAX = 131071;
  localparam longint VMIN = -131072;

  localparam logic [31:0] ATAN [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct {
    logic signed [17:0] vx;
    logic signed [17:0] vy;
    logic               rzero;
  } velocity_t;

  logic signed [19:0] ctr_x, ctr_y;
  logic [15:0]        rad_thr, loop_per;
  logic               blue;
  logic [23:0]        radius;
  velocity_t          velocity_q[$];

  function automatic longint round_shift(input longint v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [17:0] clip18(input longint v);
    if (v > VMAX) v = VMAX;
    if (v < VMIN) v = VMIN;
    return v[17:0];
  endfunction

  function automatic void bearing_of(input longint x, input longint y,
                                     output logic [31:0] ang, output longint mag);
    longint xs, ys;
    ang = '0;
    mag = 0;
    if (x == 0 && y == 0) return;
    if (x < 0) begin
      x = -x;
      y = -y;
      ang = 32'h80000000;
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; ang += ATAN[i];
      end else begin
        x -= ys; y += xs; ang -= ATAN[i];
      end
    end
    mag = round_shift(x * longint'(KGAIN), 16 + GUARD);
  endfunction

  function automatic void rotate(input longint x, input longint y, input logic [31:0] t,
                                 output longint ox, output longint oy);
    longint z, xs, ys;
    if (t[31:30] == 2'd1 || t[31:30] == 2'd2) begin
      x = -x;
      y = -y;
      t += 32'h80000000;
    end
    z = longint'($signed(t));
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(ATAN[i]);
      end else begin
        x += ys; y -= xs; z += longint'(ATAN[i]);
      end
    end
    ox = round_shift(x * longint'(KGAIN), 16 + GUARD);
    oy = round_shift(y * longint'(KGAIN), 16 + GUARD);
  endfunction

  // Returns 1 and the velocity for a drive step; updates the held radius.
  function automatic bit orbit_step(input logic act, input logic [95:0] d,
                                    output velocity_t v);
    longint px, py, rad, tang, mag, r, vx, vy;
    longint unsigned m, p, q, dv;
    logic [15:0] hd;
    logic [31:0] brg, delta, theta;
    px   = longint'($signed(d[19:0]));
    py   = longint'($signed(d[39:20]));
    rad  = longint'($signed(d[56:40]));
    tang = longint'($signed(d[73:57]));
    hd   = d[89:74];
    delta = '0;
    v.rzero = 1'b0;
    bearing_of((px - ctr_x) <<< GUARD, (py - ctr_y) <<< GUARD, brg, mag);
    if (act == ACT_CAPTURE) begin
      if (mag < 0) mag = 0;
      if (mag > RMAX) mag = RMAX;
      radius = mag[23:0];
      return 0;
    end
    if ((rad < 0 ? -rad : rad) <= longint'(rad_thr)) rad = 0;
    m = longint'(rad < 0 ? -rad : rad) * longint'(loop_per);
    m = (m + 32768) >> 16;
    r = longint'(radius) + (rad < 0 ? -longint'(m) : longint'(m));
    if (r < 0) r = 0;
    if (r > RMAX) r = RMAX;
    radius = r[23:0];
    if (r == 0) begin
      v.rzero = 1'b1;
      tang = 0;
    end else begin
      p  = longint'(tang < 0 ? -tang : tang) * longint'(loop_per);
      q  = (p * longint'(INV2PI) + 32768) >> 16;
      dv = (q + (longint'(r) >> 1)) / longint'(r);
      delta = dv[31:0];
      if (tang < 0) delta = -delta;
    end
    theta = brg + delta - {hd, 16'h0} + (blue ? 32'h80000000 : 32'h0);
    rotate(rad <<< GUARD, tang <<< GUARD, theta, vx, vy);
    v.vx = clip18(vx);
    v.vy = clip18(vy);
    return 1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    velocity_t pred, got;
    int errs;
    errs = 0;
    if (!rst_ni) begin
      ctr_x    <= '0;
      ctr_y    <= '0;
      rad_thr  <= 16'd4608;
      loop_per <= 16'd1311;
      blue     <= 1'b0;
      radius    = '0;
      velocity_q.delete();
      err_cnt_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CENTER_X:   ctr_x    <= cfg_data_i;
          CFG_CENTER_Y:   ctr_y    <= cfg_data_i;
          CFG_RADIAL_THR: rad_thr  <= cfg_data_i[15:0];
          CFG_LOOP_PER:   loop_per <= cfg_data_i[15:0];
          CFG_BLUE_SIDE:  blue     <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (orbit_step(s_axis_tuser, s_axis_tdata, pred)) velocity_q.push_back(pred);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.vx    = m_axis_tdata[17:0];
        got.vy    = m_axis_tdata[35:18];
        got.rzero = m_axis_tuser;
        if (velocity_q.size() == 0) begin
          $error("unexpected result vx=%0d vy=%0d radius_zero=%0b", got.vx, got.vy, got.rzero);
          errs++;
        end else begin
          pred = velocity_q.pop_front();
          if (got.vx !== pred.vx) begin
            $error("robot_vx expected %0d got %0d", pred.vx, got.vx);
            errs++;
          end
          if (got.vy !== pred.vy) begin
            $error("robot_vy expected %0d got %0d", pred.vy, got.vy);
            errs++;
          end
          if (got.rzero !== pred.rzero) begin
            $error("radius_zero expected %0b got %0b", pred.rzero, got.rzero);
            errs++;
          end
        end
      end
      err_cnt_o <= err_cnt_o + errs;
      pending_o <= velocity_q.size();
    end
  end

endmodule

// ----- tb/tb_polar_orbit_velocity_transform_core.sv -----
// Stimulus and verdict for the polar orbit velocity transform core.
module tb_polar_orbit_velocity_transform_core;
  timeunit 1ns;
  timeprecision 1ps;
  import pov_pkg::*;

  localparam logic ACT_DRIVE = ~ACT_CAPTURE;
  localparam int   SETTLE    = 2 * CORDIC_STEPS_DEF + 80;

  logic                  clk, rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_valid, s_ready, s_user;
  logic [IN_DATA_W-1:0]  s_data;
  logic                  m_valid, m_ready, m_user;
  logic [OUT_DATA_W-1:0] m_data;
  int                    err_cnt, pending;

  // idle and stall odds, percent of cycles
  int tx_idle, rx_stall;
  int hold_req, hold_seen, hold_left;

  polar_orbit_velocity_transform_core dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .s_axis_tvalid(s_valid), .s_axis_tready(s_ready),
    .s_axis_tdata(s_data), .s_axis_tuser(s_user),
    .m_axis_tvalid(m_valid), .m_axis_tready(m_ready),
    .m_axis_tdata(m_data), .m_axis_tuser(m_user)
  );

  pov_checker chk (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .s_axis_tvalid(s_valid), .s_axis_tready(s_ready),
    .s_axis_tdata(s_data), .s_axis_tuser(s_user),
    .m_axis_tvalid(m_valid), .m_axis_tready(m_ready),
    .m_axis_tdata(m_data), .m_axis_tuser(m_user),
    .err_cnt_o(err_cnt), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("[polar_orbit_velocity_transform_core] ERROR");
    $finish;
  end

  // result side: random stalls plus one long hold-off when requested
  initial begin
    m_ready   = 1'b0;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = 600;
        m_ready <= 1'b0;
      end else begin
        m_ready <= ($urandom_range(99) >= rx_stall);
      end
    end
  end

  task automatic send_pose(input logic act, input logic [19:0] px, input logic [19:0] py,
                           input logic [16:0] rad, input logic [16:0] tang,
                           input logic [15:0] hd);
    while ($urandom_range(99) < tx_idle) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_user  <= act;
    s_data  <= {6'b0, hd, tang, rad, py, px};
    @(posedge clk);
    while (!s_ready) @(posedge clk);
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_orbit(input logic [19:0] cx, input logic [19:0] cy,
                           input logic [15:0] thr, input logic [15:0] lp, input logic bl);
    drain();
    write_reg(CFG_CENTER_X, cx);
    write_reg(CFG_CENTER_Y, cy);
    write_reg(CFG_RADIAL_THR, {4'b0, thr});
    write_reg(CFG_LOOP_PER, {4'b0, lp});
    write_reg(CFG_BLUE_SIDE, {19'b0, bl});
  endtask

  function automatic logic [16:0] pick_speed();
    case ($urandom_range(3))
      0: return 17'($signed($urandom_range(6000)) - 3000);
      1: return {17{1'($urandom_range(1))}} ^ 17'($urandom_range(8191));
      default: return 17'($urandom);
    endcase
  endfunction

  // capture then a short run of drive steps; a slice of pure noise
  task automatic random_run(input int count);
    logic [19:0] px, py;
    int n;
    n = 0;
    while (n < count) begin
      if ($urandom_range(9) == 0) begin
        send_pose(1'($urandom_range(1)), 20'($urandom), 20'($urandom), 17'($urandom),
                  17'($urandom), 16'($urandom));
        n++;
      end else begin
        if ($urandom_range(1) == 0) begin
          px = 20'($signed(chk.ctr_x) + $signed($urandom_range(64)) - 32);
          py = 20'($signed(chk.ctr_y) + $signed($urandom_range(64)) - 32);
        end else begin
          px = 20'($urandom);
          py = 20'($urandom);
        end
        send_pose(ACT_CAPTURE, px, py, 17'($urandom), 17'($urandom), 16'($urandom));
        n++;
        repeat ($urandom_range(1, 6)) begin
          send_pose(ACT_DRIVE, px ^ 20'($urandom_range(255)), py ^ 20'($urandom_range(255)),
                    pick_speed(), pick_speed(), 16'($urandom));
          n++;
        end
      end
    end
  endtask

  initial begin
    rst_n    = 1'b0;
    cfg_we   = 1'b0;
    cfg_idx  = '0;
    cfg_data = '0;
    s_valid  = 1'b0;
    s_user   = 1'b0;
    s_data   = '0;
    tx_idle  = 0;
    rx_stall = 0;
    hold_req = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: drive on zero radius, pose on the center, extremes, threshold edge
    send_pose(ACT_DRIVE, 20'd5, 20'd7, 17'd0, 17'd3000, 16'd0);
    send_pose(ACT_CAPTURE, 20'd0, 20'd0, 17'd0, 17'd0, 16'd0);
    send_pose(ACT_DRIVE, 20'd0, 20'd0, 17'h0FFFF, 17'h10000, 16'hFFFF);
    send_pose(ACT_CAPTURE, 20'h80000, 20'h80000, 17'd0, 17'd0, 16'd0);
    send_pose(ACT_DRIVE, 20'h80000, 20'h80000, 17'd4608, 17'h0FFFF, 16'h4000);
    send_pose(ACT_DRIVE, 20'h7FFFF, 20'h80000, 17'd4609, 17'h10000, 16'h8000);
    send_pose(ACT_DRIVE, 20'h7FFFF, 20'h7FFFF, -17'sd4608, 17'd1, 16'hC000);
    send_pose(ACT_DRIVE, 20'h80000, 20'h7FFFF, 17'h10000, 17'h1FFFF, 16'hFFFF);
    send_pose(ACT_CAPTURE, 20'd4096, 20'd0, 17'd0, 17'd0, 16'd0);
    send_pose(ACT_DRIVE, 20'd4096, 20'd0, 17'h10000, 17'h0FFFF, 16'h1234);
    send_pose(ACT_DRIVE, 20'd4096, 20'd0, 17'h10000, 17'h10000, 16'hFEDC);
    send_pose(ACT_DRIVE, 20'h7FFFF, 20'd0, 17'h0FFFF, 17'h0FFFF, 16'h0001);
    send_pose(ACT_CAPTURE, 20'hFFFFF, 20'd1, 17'h1FFFF, 17'h1FFFF, 16'hFFFF);
    send_pose(ACT_DRIVE, 20'h00001, 20'hFFFFF, 17'd0, 17'h10000, 16'h7FFF);

    // receiver holds off while items keep coming
    hold_req++;
    random_run(30);
    random_run(370);

    set_orbit(20'h80000, 20'h7FFFF, 16'd0, 16'hFFFF, 1'b1);
    tx_idle = 80;
    random_run(400);

    set_orbit(20'($urandom), 20'($urandom), 16'hFFFF, 16'd0, 1'b0);
    tx_idle  = 0;
    rx_stall = 80;
    random_run(400);

    set_orbit(20'($urandom_range(8191)), 20'h80000 + 20'($urandom_range(8191)),
              16'($urandom_range(8000)), 16'($urandom), 1'b1);
    tx_idle  = 7;
    rx_stall = 7;
    random_run(400);

    s_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (err_cnt == 0) begin
      $display("[polar_orbit_velocity_transform_core] OK");
    end else begin
      $display("[polar_orbit_velocity_transform_core] ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/pov_pkg.sv
src/pov_ctrl.sv
src/pov_dp.sv
src/polar_orbit_velocity_transform_core.sv
tb/pov_checker.sv
tb/tb_polar_orbit_velocity_transform_core.sv
